// ----- design/vector_angle_and_length_unit_macros.svh -----
// Assertion helpers for the vector angle and length unit
`ifndef VECTOR_ANGLE_AND_LENGTH_UNIT_MACROS_SVH
`define VECTOR_ANGLE_AND_LENGTH_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define VALU_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge
`define VALU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/valu_pkg.sv -----
package valu_pkg;

  localparam int GUARD = 12;
  localparam int ATAN_ENTRIES = 24;
  localparam int MUL_SPLIT = 16;
  localparam int ROUND_SHIFT = MUL_SPLIT + GUARD;
  localparam int LEN_BITS = 17;
  localparam logic [LEN_BITS-1:0] LEN_MAX = 17'd131071;
  localparam logic [31:0] INV_GAIN = 32'd2608131496;
  localparam logic [31:0] ROUND_HALF = 32'd1 << (ROUND_SHIFT - 1);
  localparam logic [31:0] TURN_ZERO = 32'h0000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;
  localparam int FIFO_PTR_BITS = 1;
  localparam int FIFO_DEPTH = 1 << FIFO_PTR_BITS;
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_VERTICAL,
    KIND_HORIZONTAL,
    KIND_GENERAL
  } item_kind_e;

  function automatic logic [31:0] atan_turn(input int idx);
    case (idx)
      0:  return 32'h20000000;
      1:  return 32'h12E4051D;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2E;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2F9;
      15: return 32'h0000517C;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A2F;
      19: return 32'h00000517;
      20: return 32'h0000028B;
      21: return 32'h00000145;
      22: return 32'h000000A2;
      23: return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

// ----- design/vector_angle_and_length_unit.sv -----
// Path: input register, queue, rotation stages, multiply register, output register.
// Throughput: one transaction per cycle, set by the back-end rotation pipeline, while the output is ready.
// A two-entry queue parts the input register from the rotation pipeline.
// Reset (rst_ni low, asynchronous) empties the queue and clears all valid flags;
// payload registers keep their contents.
`include "vector_angle_and_length_unit_macros.svh"

module vector_angle_and_length_unit #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16,
  parameter int ROTATIONS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // start_x, start_y, end_x, end_y (COORD_BITS each), zero padding
  input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // angle (ANGLE_BITS), length (17), zero padding
  output logic [((ANGLE_BITS + valu_pkg::LEN_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int OUT_W = ((ANGLE_BITS + valu_pkg::LEN_BITS + 7) / 8) * 8;
  localparam int NROT  = (ROTATIONS > valu_pkg::ATAN_ENTRIES) ? valu_pkg::ATAN_ENTRIES : ROTATIONS;
  localparam int W     = COORD_BITS + valu_pkg::GUARD + 3;
  localparam int DW    = 2 * W + COORD_BITS + 34;

  logic fe_valid, fe_ready, bk_valid, bk_ready;
  logic [DW-1:0] fe_item, bk_item;
  logic [ANGLE_BITS-1:0] angle;
  logic [valu_pkg::LEN_BITS-1:0] length;

  valu_front #(
    .COORD_BITS(COORD_BITS),
    .DW        (DW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .start_x_i  (s_axis_tdata[COORD_BITS-1:0]),
    .start_y_i  (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x_i    (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y_i    (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .out_valid_o(fe_valid),
    .out_ready_i(fe_ready),
    .out_item_o (fe_item)
  );

  valu_fifo #(
    .DW(DW)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fe_valid),
    .wr_ready_o(fe_ready),
    .wr_data_i (fe_item),
    .rd_valid_o(bk_valid),
    .rd_ready_i(bk_ready),
    .rd_data_o (bk_item)
  );

  valu_back #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS),
    .NROT      (NROT),
    .DW        (DW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bk_valid),
    .in_ready_o (bk_ready),
    .in_item_i  (bk_item),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .angle_o    (angle),
    .length_o   (length)
  );

  assign m_axis_tdata = OUT_W'({length, angle});

  `VALU_ASSERT_HOLDS(a_front_stall_blocks_input, fe_valid && !fe_ready, !s_axis_tready)
  `VALU_ASSERT_HOLDS(a_back_stall_from_output, bk_valid && !bk_ready, m_axis_tvalid && !m_axis_tready)
  `VALU_ASSERT_NEXT(a_accept_loads_front, s_axis_tvalid && s_axis_tready, fe_valid)

endmodule

// ----- design/valu_fifo.sv -----
module valu_fifo #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  logic [DW-1:0] wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [valu_pkg::FIFO_DEPTH];
  logic [valu_pkg::FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [valu_pkg::FIFO_CNT_BITS-1:0] cnt_q, cnt_d;
  logic wr_en, rd_en;

  assign wr_ready_o = (cnt_q != valu_pkg::FIFO_CNT_BITS'(valu_pkg::FIFO_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- design/valu_front.sv -----
module valu_front #(
  parameter int COORD_BITS = 16,
  parameter int DW = 2 * (COORD_BITS + valu_pkg::GUARD + 3) + COORD_BITS + 34
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DW-1:0]                out_item_o
);

  localparam int W = COORD_BITS + valu_pkg::GUARD + 3;

  typedef struct packed {
    logic                  bypass;
    logic [COORD_BITS:0]   mag;
    logic [31:0]           acc;
    logic signed [W-1:0]   x;
    logic signed [W-1:0]   y;
  } item_t;

  item_t item_d, item_q;
  logic fe_v_q, fe_v_d;
  logic accept;
  valu_pkg::item_kind_e kind;
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0] adx, ady;
  logic signed [W-1:0] xs, ys;

  assign in_ready_o  = !fe_v_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = fe_v_q;
  assign out_item_o  = item_q;

  always_comb begin
    dx  = (COORD_BITS + 1)'(end_x_i) - (COORD_BITS + 1)'(start_x_i);
    dy  = (COORD_BITS + 1)'(start_y_i) - (COORD_BITS + 1)'(end_y_i);
    adx = dx[COORD_BITS] ? -dx : dx;
    ady = dy[COORD_BITS] ? -dy : dy;
    xs  = W'(dx) <<< valu_pkg::GUARD;
    ys  = W'(dy) <<< valu_pkg::GUARD;
    if (dx == '0 && dy == '0) begin
      kind = valu_pkg::KIND_ZERO;
    end else if (dx == '0) begin
      kind = valu_pkg::KIND_VERTICAL;
    end else if (dy == '0) begin
      kind = valu_pkg::KIND_HORIZONTAL;
    end else begin
      kind = valu_pkg::KIND_GENERAL;
    end
  end

  always_comb begin
    item_d.bypass = 1'b1;
    item_d.mag    = '0;
    item_d.acc    = valu_pkg::TURN_ZERO;
    item_d.x      = xs;
    item_d.y      = ys;
    case (kind)
      valu_pkg::KIND_ZERO: begin
        item_d.bypass = 1'b1;
      end
      valu_pkg::KIND_VERTICAL: begin
        item_d.mag = ady;
        item_d.acc = dy[COORD_BITS] ? valu_pkg::THREE_QUARTER_TURN : valu_pkg::QUARTER_TURN;
      end
      valu_pkg::KIND_HORIZONTAL: begin
        item_d.mag = adx;
        item_d.acc = dx[COORD_BITS] ? valu_pkg::HALF_TURN : valu_pkg::TURN_ZERO;
      end
      valu_pkg::KIND_GENERAL: begin
        item_d.bypass = 1'b0;
        if (dx[COORD_BITS]) begin
          item_d.x   = -xs;
          item_d.y   = -ys;
          item_d.acc = valu_pkg::HALF_TURN;
        end
      end
      default: begin
        item_d.bypass = 1'b1;
      end
    endcase
  end

  always_comb begin
    fe_v_d = fe_v_q;
    if (accept) begin
      fe_v_d = 1'b1;
    end else if (out_ready_i) begin
      fe_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_v_q <= 1'b0;
    end else begin
      fe_v_q <= fe_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- design/valu_back.sv -----
module valu_back #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16,
  parameter int NROT = 16,
  parameter int DW = 2 * (COORD_BITS + valu_pkg::GUARD + 3) + COORD_BITS + 34
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [DW-1:0]                 in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ANGLE_BITS-1:0]         angle_o,
  output logic [valu_pkg::LEN_BITS-1:0] length_o
);

  localparam int W    = COORD_BITS + valu_pkg::GUARD + 3;
  localparam int XU   = W - 1;
  localparam int PH   = XU - valu_pkg::MUL_SPLIT + 32;
  localparam int PL   = valu_pkg::MUL_SPLIT + 32;
  localparam int SW   = XU + 17;
  localparam int LW   = SW - valu_pkg::ROUND_SHIFT;
  localparam int CMPW = (LW > valu_pkg::LEN_BITS) ? LW : valu_pkg::LEN_BITS;
  localparam logic [31:0] ANGLE_HALF = 32'd1 << (31 - ANGLE_BITS);

  typedef struct packed {
    logic                  bypass;
    logic [COORD_BITS:0]   mag;
    logic [31:0]           acc;
    logic signed [W-1:0]   x;
    logic signed [W-1:0]   y;
  } item_t;

  function automatic item_t rotate(input item_t s, input int k);
    item_t r;
    logic signed [W-1:0] xo, yo, xsh, ysh;
    r   = s;
    xo  = s.x;
    yo  = s.y;
    xsh = xo >>> k;
    ysh = yo >>> k;
    if (!s.bypass) begin
      if (yo > 0) begin
        r.x   = xo + ysh;
        r.y   = yo - xsh;
        r.acc = s.acc + valu_pkg::atan_turn(k);
      end else begin
        r.x   = xo - ysh;
        r.y   = yo + xsh;
        r.acc = s.acc - valu_pkg::atan_turn(k);
      end
    end
    return r;
  endfunction

  item_t in_item;
  item_t stg_q [NROT];
  logic [NROT-1:0] stg_v_q;
  logic adv;

  logic [XU-1:0] xc;
  logic [PL-1:0] prod_lo_q;
  logic [PH-1:0] prod_hi_q;
  logic mul_v_q, mul_bypass_q;
  logic [COORD_BITS:0] mul_mag_q;
  logic [31:0] mul_acc_q;

  logic [SW-1:0] sum;
  logic [LW-1:0] len_sel;
  logic [valu_pkg::LEN_BITS-1:0] len_sat;
  logic [31:0] acc_rnd;

  logic out_v_q;
  logic [ANGLE_BITS-1:0] angle_q;
  logic [valu_pkg::LEN_BITS-1:0] length_q;

  assign in_item     = in_item_i;
  assign adv         = !out_v_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_v_q;
  assign angle_o     = angle_q;
  assign length_o    = length_q;

  always_comb begin
    xc = stg_q[NROT-1].x[W-1] ? '0 : stg_q[NROT-1].x[XU-1:0];
  end

  always_comb begin
    sum = SW'(prod_hi_q) + SW'(valu_pkg::ROUND_HALF)
        + SW'(prod_lo_q[PL-1:valu_pkg::MUL_SPLIT]);
    len_sel = mul_bypass_q ? LW'(mul_mag_q) : sum[SW-1:valu_pkg::ROUND_SHIFT];
    if (CMPW'(len_sel) > CMPW'(valu_pkg::LEN_MAX)) begin
      len_sat = valu_pkg::LEN_MAX;
    end else begin
      len_sat = valu_pkg::LEN_BITS'(len_sel);
    end
    acc_rnd = mul_acc_q + ANGLE_HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
      mul_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      stg_v_q <= {stg_v_q[NROT-2:0], in_valid_i};
      mul_v_q <= stg_v_q[NROT-1];
      out_v_q <= mul_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0] <= rotate(in_item, 0);
      for (int k = 1; k < NROT; k++) begin
        stg_q[k] <= rotate(stg_q[k-1], k);
      end
      prod_lo_q    <= PL'(xc[valu_pkg::MUL_SPLIT-1:0]) * PL'(valu_pkg::INV_GAIN);
      prod_hi_q    <= PH'(xc[XU-1:valu_pkg::MUL_SPLIT]) * PH'(valu_pkg::INV_GAIN);
      mul_bypass_q <= stg_q[NROT-1].bypass;
      mul_mag_q    <= stg_q[NROT-1].mag;
      mul_acc_q    <= stg_q[NROT-1].acc;
      angle_q      <= acc_rnd[31 -: ANGLE_BITS];
      length_q     <= len_sat;
    end
  end

endmodule
